>>> hdl/rvx_pkg.sv
// Shared types, opcodes and code constants for the RV32IM execute core.
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW   = 5;

  localparam logic [31:0] START_PC_RESET = 32'h0000_0000;
  localparam logic [31:0] UPPER_MASK     = 32'hFFFF_F000;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // funct7 codes of the register-register group
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // Multiply funct3
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;

  // Result kinds
  localparam logic [1:0] KIND_RETIRE = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_STORE  = 2'd2;
  localparam logic [1:0] KIND_HALT   = 2'd3;

  // Access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Request types
  localparam logic REQ_INSTR = 1'b0;
  localparam logic REQ_LDATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DIV
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RES_ALU,
    RES_MUL,
    RES_DIV
  } res_sel_t;

  typedef struct packed {
    logic     latch;
    logic     mul_capture;
    logic     div_start;
    logic     commit;
    res_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_done;
  } dp_stat_t;

endpackage

>>> hdl/rv32im_execute_core_unit.sv
// Top level of the RV32IM execute core: sequencer, datapath and configuration registers.
`timescale 1ns / 1ps
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// request   | in_req_type, in_instr_word, in_load_data  | taken when start && !busy
// result    | out_result_kind ... out_wb_value          | out_valid, one cycle, no stall
// config    | psel penable pwrite paddr pwdata prdata   | APB, write in access phase
//
// An accepted request passes the READ and EXEC states before the result strobe for plain
// instructions and load data; multiplies add MUL (one registered multiplier stage), divides
// and remainders wait in DIV (the radix-2 divider retires one quotient bit per cycle).
// busy holds from the accepting edge until the edge that registers the result, so the next
// request may be taken in the very cycle the previous result is on the ports.
// Synchronous reset clears the register file valid bits, the pc (to the start_pc reset
// value) and the pending load; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
module rv32im_execute_core_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [31:0]                in_instr_word,
  input  logic [31:0]                in_load_data,
  // result
  output logic                       out_valid,
  output logic [1:0]                 out_result_kind,
  output logic [31:0]                out_pc_next,
  output logic [31:0]                out_mem_addr,
  output logic [31:0]                out_mem_wdata,
  output logic [1:0]                 out_mem_size,
  output logic                       out_wb_valid,
  output logic [rvx_pkg::REG_AW-1:0] out_wb_reg,
  output logic [31:0]                out_wb_value,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [1:0] CFG_ADDR_START_PC = 2'd0;

  rvx_pkg::dp_cmd_t  cmd;
  rvx_pkg::dp_stat_t stat;
  logic [31:0]       start_pc_r;

  // Sequencer
  rvx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: only command and status cross between the two
  rvx_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_instr_word   (in_instr_word),
    .in_load_data    (in_load_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_pc_next     (out_pc_next),
    .out_mem_addr    (out_mem_addr),
    .out_mem_wdata   (out_mem_wdata),
    .out_mem_size    (out_mem_size),
    .out_wb_valid    (out_wb_valid),
    .out_wb_reg      (out_wb_reg),
    .out_wb_value    (out_wb_value)
  );

  // start_pc: the pc is loaded with its reset value at reset; a later write only
  // changes the stored register, the running pc is left alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= rvx_pkg::START_PC_RESET;
    end else if (psel && penable && pwrite) begin
      start_pc_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_START_PC) ? start_pc_r : '0;

`ifndef NO_ASSERTIONS
  // The result strobe comes with the sequencer back in idle
  a_out_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // An accepted request always occupies the sequencer on the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Results are never back to back: each request passes the READ and EXEC states
  a_out_spaced : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in consecutive cycles");
`endif

endmodule

>>> hdl/rvx_regfile.sv
// Integer register file: one write port, two registered read ports, x0 reads zero.
`timescale 1ns / 1ps
module rvx_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [rvx_pkg::REG_AW-1:0] waddr,
  input  logic [rvx_pkg::XLEN-1:0]   wdata,
  input  logic [rvx_pkg::REG_AW-1:0] raddr_a,
  input  logic [rvx_pkg::REG_AW-1:0] raddr_b,
  output logic [rvx_pkg::XLEN-1:0]   rdata_a,
  output logic [rvx_pkg::XLEN-1:0]   rdata_b
);

  logic [rvx_pkg::XLEN-1:0]     mem [rvx_pkg::NUM_REGS];
  logic [rvx_pkg::NUM_REGS-1:0] vld_r;
  logic [rvx_pkg::XLEN-1:0]     rd_a_r;
  logic [rvx_pkg::XLEN-1:0]     rd_b_r;
  logic                         vld_a_r;
  logic                         vld_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // Entries never written since reset read as zero; x0 is never marked valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (we && (waddr != '0)) begin
        vld_r[waddr] <= 1'b1;
      end
      vld_a_r <= vld_r[raddr_a];
      vld_b_r <= vld_r[raddr_b];
    end
  end

  assign rdata_a = vld_a_r ? rd_a_r : '0;
  assign rdata_b = vld_b_r ? rd_b_r : '0;

endmodule

>>> hdl/rvx_divider.sv
// Radix-2 restoring divider for DIV, DIVU, REM and REMU, one quotient bit per cycle.
`timescale 1ns / 1ps
module rvx_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    op_signed,
  input  logic                    rem_sel,
  input  logic [rvx_pkg::XLEN-1:0] dividend,
  input  logic [rvx_pkg::XLEN-1:0] divisor,
  output logic                    done,
  output logic [rvx_pkg::XLEN-1:0] result
);

  localparam logic [5:0] DIV_STEPS = 6'd32;

  logic        run_r,   run_nxt;
  logic [5:0]  cnt_r,   cnt_nxt;
  logic [31:0] quo_r,   quo_nxt;
  logic [31:0] rem_r,   rem_nxt;
  logic [31:0] ub_r,    ub_nxt;
  logic [31:0] a_r,     a_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic        bzero_r, bzero_nxt;
  logic        rsel_r,  rsel_nxt;

  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign done   = run_r && (cnt_r == '0);
  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, ub_r};

  always_comb begin
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    ub_nxt    = ub_r;
    a_nxt     = a_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    bzero_nxt = bzero_r;
    rsel_nxt  = rsel_r;
    if (start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = DIV_STEPS;
      quo_nxt   = (op_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
      ub_nxt    = (op_signed && divisor[31]) ? (32'd0 - divisor) : divisor;
      rem_nxt   = '0;
      a_nxt     = dividend;
      neg_q_nxt = op_signed && (dividend[31] ^ divisor[31]);
      neg_r_nxt = op_signed && dividend[31];
      bzero_nxt = (divisor == '0);
      rsel_nxt  = rem_sel;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!diff[32]) begin
          rem_nxt = diff[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    ub_r    <= ub_nxt;
    a_r     <= a_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    bzero_r <= bzero_nxt;
    rsel_r  <= rsel_nxt;
  end

  always_comb begin
    if (bzero_r) begin
      result = rsel_r ? a_r : '1;
    end else if (rsel_r) begin
      result = neg_r_r ? (32'd0 - rem_r) : rem_r;
    end else begin
      result = neg_q_r ? (32'd0 - quo_r) : quo_r;
    end
  end

endmodule

>>> hdl/rvx_datapath.sv
// Execute datapath: request latch, decode, ALU, multiplier, divider, pc and load tracking.
`timescale 1ns / 1ps
module rvx_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_req_type,
  input  logic [31:0]                in_instr_word,
  input  logic [31:0]                in_load_data,
  input  rvx_pkg::dp_cmd_t           cmd,
  output rvx_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  output logic [1:0]                 out_result_kind,
  output logic [31:0]                out_pc_next,
  output logic [31:0]                out_mem_addr,
  output logic [31:0]                out_mem_wdata,
  output logic [1:0]                 out_mem_size,
  output logic                       out_wb_valid,
  output logic [rvx_pkg::REG_AW-1:0] out_wb_reg,
  output logic [31:0]                out_wb_value
);

  logic        type_r;
  logic [31:0] ir_r;
  logic [31:0] ld_r;
  logic [31:0] pc_r,    pc_nxt;
  logic        lp_r,    lp_nxt;
  logic [4:0]  ldest_r, ldest_nxt;
  logic [2:0]  lfmt_r,  lfmt_nxt;
  logic [63:0] prod_r;
  logic        out_valid_r;

  logic [1:0]  kind_nxt;
  logic [31:0] addr_nxt;
  logic [31:0] wdata_nxt;
  logic [1:0]  size_nxt;
  logic        wb_nxt;
  logic [4:0]  wreg_nxt;
  logic [31:0] wval_nxt;

  logic [1:0]  kind_r;
  logic [31:0] pcn_r;
  logic [31:0] addr_r;
  logic [31:0] wdata_r;
  logic [1:0]  size_r;
  logic        wb_r;
  logic [4:0]  wreg_r;
  logic [31:0] wval_r;

  logic [31:0] a, b;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immj;
  logic [31:0] opb;
  logic [32:0] ma, mb;
  logic [65:0] prod;
  logic        div_done;
  logic [31:0] div_res;

  assign op   = ir_r[6:0];
  assign rd   = ir_r[11:7];
  assign f3   = ir_r[14:12];
  assign f7   = ir_r[31:25];
  assign immi = {{20{ir_r[31]}}, ir_r[31:20]};
  assign imms = {{20{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign immb = {{20{ir_r[31]}}, ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign immj = {{12{ir_r[31]}}, ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign opb  = (op == rvx_pkg::OPC_OP) ? b : immi;

  rvx_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (cmd.commit && wb_nxt),
    .waddr   (wreg_nxt),
    .wdata   (wval_nxt),
    .raddr_a (ir_r[19:15]),
    .raddr_b (ir_r[24:20]),
    .rdata_a (a),
    .rdata_b (b)
  );

  rvx_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .op_signed (!f3[0]),
    .rem_sel   (f3[1]),
    .dividend  (a),
    .divisor   (b),
    .done      (div_done),
    .result    (div_res)
  );

  // Sign-extend operands per multiply flavour; low word is the same for all
  assign ma   = {((f3 == rvx_pkg::F3_MULH) || (f3 == rvx_pkg::F3_MULHSU)) && a[31], a};
  assign mb   = {(f3 == rvx_pkg::F3_MULH) && b[31], b};
  assign prod = $signed(ma) * $signed(mb);

  always_comb begin
    stat.is_mul   = (type_r == rvx_pkg::REQ_INSTR) && (op == rvx_pkg::OPC_OP)
                    && (f7 == rvx_pkg::F7_MULDIV) && !f3[2];
    stat.is_div   = (type_r == rvx_pkg::REQ_INSTR) && (op == rvx_pkg::OPC_OP)
                    && (f7 == rvx_pkg::F7_MULDIV) && f3[2];
    stat.div_done = div_done;
  end

  always_comb begin
    logic        w;
    logic [31:0] v;
    logic [31:0] alu;
    logic        taken;
    logic [31:0] ld;
    w         = 1'b0;
    v         = '0;
    alu       = '0;
    taken     = 1'b0;
    ld        = ld_r;
    kind_nxt  = rvx_pkg::KIND_RETIRE;
    pc_nxt    = pc_r;
    addr_nxt  = '0;
    wdata_nxt = '0;
    size_nxt  = rvx_pkg::SIZE_BYTE;
    wb_nxt    = 1'b0;
    wreg_nxt  = '0;
    wval_nxt  = '0;
    lp_nxt    = lp_r;
    ldest_nxt = ldest_r;
    lfmt_nxt  = lfmt_r;

    case (f3)
      rvx_pkg::F3_ADD:  alu = a + opb;
      rvx_pkg::F3_SLL:  alu = a << opb[4:0];
      rvx_pkg::F3_SLT:  alu = {31'd0, $signed(a) < $signed(opb)};
      rvx_pkg::F3_SLTU: alu = {31'd0, a < opb};
      rvx_pkg::F3_XOR:  alu = a ^ opb;
      rvx_pkg::F3_SRL:  alu = ir_r[30] ? 32'($signed(a) >>> opb[4:0]) : (a >> opb[4:0]);
      rvx_pkg::F3_OR:   alu = a | opb;
      default:          alu = a & opb;
    endcase

    if (type_r == rvx_pkg::REQ_LDATA) begin
      if (lp_r) begin
        case (lfmt_r)
          rvx_pkg::F3_LB:  ld = {{24{ld_r[7]}}, ld_r[7:0]};
          rvx_pkg::F3_LH:  ld = {{16{ld_r[15]}}, ld_r[15:0]};
          rvx_pkg::F3_LBU: ld = {24'd0, ld_r[7:0]};
          rvx_pkg::F3_LHU: ld = {16'd0, ld_r[15:0]};
          default:         ld = ld_r;
        endcase
        lp_nxt = 1'b0;
        if (ldest_r != '0) begin
          wb_nxt   = 1'b1;
          wreg_nxt = ldest_r;
          wval_nxt = ld;
        end
      end
    end else begin
      pc_nxt = pc_r + 32'd4;
      case (op)
        rvx_pkg::OPC_OP: begin
          if (f7 == rvx_pkg::F7_MULDIV) begin
            w = 1'b1;
            case (cmd.sel)
              rvx_pkg::RES_MUL: v = (f3 == rvx_pkg::F3_MUL) ? prod_r[31:0] : prod_r[63:32];
              rvx_pkg::RES_DIV: v = div_res;
              default:          v = '0;
            endcase
          end else if (f7 == rvx_pkg::F7_BASE) begin
            w = 1'b1;
            v = alu;
          end else if ((f7 == rvx_pkg::F7_ALT) && (f3 == rvx_pkg::F3_ADD)) begin
            w = 1'b1;
            v = a - b;
          end else if ((f7 == rvx_pkg::F7_ALT) && (f3 == rvx_pkg::F3_SRL)) begin
            w = 1'b1;
            v = alu;
          end
        end
        rvx_pkg::OPC_OP_IMM: begin
          w = 1'b1;
          v = alu;
        end
        rvx_pkg::OPC_LOAD: begin
          if (f3 inside {rvx_pkg::F3_LB, rvx_pkg::F3_LH, rvx_pkg::F3_LW,
                         rvx_pkg::F3_LBU, rvx_pkg::F3_LHU}) begin
            kind_nxt  = rvx_pkg::KIND_LOAD;
            addr_nxt  = a + immi;
            size_nxt  = f3[1:0];
            lp_nxt    = 1'b1;
            ldest_nxt = rd;
            lfmt_nxt  = f3;
          end
        end
        rvx_pkg::OPC_JALR: begin
          if (f3 == 3'd0) begin
            w      = 1'b1;
            v      = pc_r + 32'd4;
            pc_nxt = (a + immi) & ~32'd1;
          end
        end
        rvx_pkg::OPC_SYSTEM: kind_nxt = rvx_pkg::KIND_HALT;
        rvx_pkg::OPC_STORE: begin
          if (f3 <= 3'd2) begin
            kind_nxt = rvx_pkg::KIND_STORE;
            addr_nxt = a + imms;
            size_nxt = f3[1:0];
            case (f3[1:0])
              rvx_pkg::SIZE_BYTE: wdata_nxt = {24'd0, b[7:0]};
              rvx_pkg::SIZE_HALF: wdata_nxt = {16'd0, b[15:0]};
              default:            wdata_nxt = b;
            endcase
          end
        end
        rvx_pkg::OPC_BRANCH: begin
          case (f3)
            rvx_pkg::F3_BEQ:  taken = (a == b);
            rvx_pkg::F3_BNE:  taken = (a != b);
            rvx_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
            rvx_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
            rvx_pkg::F3_BLTU: taken = (a < b);
            rvx_pkg::F3_BGEU: taken = (a >= b);
            default:          taken = 1'b0;
          endcase
          if (taken) begin
            pc_nxt = pc_r + immb;
          end
        end
        rvx_pkg::OPC_LUI: begin
          w = 1'b1;
          v = ir_r & rvx_pkg::UPPER_MASK;
        end
        rvx_pkg::OPC_AUIPC: begin
          w = 1'b1;
          v = pc_r + (ir_r & rvx_pkg::UPPER_MASK);
        end
        rvx_pkg::OPC_JAL: begin
          w      = 1'b1;
          v      = pc_r + 32'd4;
          pc_nxt = pc_r + immj;
        end
        default: w = 1'b0;
      endcase
      if (w && (rd != '0)) begin
        wb_nxt   = 1'b1;
        wreg_nxt = rd;
        wval_nxt = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= rvx_pkg::START_PC_RESET;
      lp_r        <= 1'b0;
      ldest_r     <= '0;
      lfmt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        pc_r    <= pc_nxt;
        lp_r    <= lp_nxt;
        ldest_r <= ldest_nxt;
        lfmt_r  <= lfmt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      type_r <= in_req_type;
      ir_r   <= in_instr_word;
      ld_r   <= in_load_data;
    end
    if (cmd.mul_capture) begin
      prod_r <= prod[63:0];
    end
    if (cmd.commit) begin
      kind_r  <= kind_nxt;
      pcn_r   <= pc_nxt;
      addr_r  <= addr_nxt;
      wdata_r <= wdata_nxt;
      size_r  <= size_nxt;
      wb_r    <= wb_nxt;
      wreg_r  <= wreg_nxt;
      wval_r  <= wval_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_pc_next     = pcn_r;
  assign out_mem_addr    = addr_r;
  assign out_mem_wdata   = wdata_r;
  assign out_mem_size    = size_r;
  assign out_wb_valid    = wb_r;
  assign out_wb_reg      = wreg_r;
  assign out_wb_value    = wval_r;

endmodule

>>> hdl/rvx_ctrl.sv
// Sequencing state machine: accept, operand read, execute, multiply and divide waits.
`timescale 1ns / 1ps
module rvx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rvx_pkg::dp_stat_t stat,
  output logic              busy,
  output rvx_pkg::dp_cmd_t  cmd
);

  rvx_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd.latch       = 1'b0;
    cmd.mul_capture = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.commit      = 1'b0;
    cmd.sel         = rvx_pkg::RES_ALU;
    case (state_r)
      rvx_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = rvx_pkg::ST_READ;
        end
      end
      rvx_pkg::ST_READ: state_nxt = rvx_pkg::ST_EXEC;
      rvx_pkg::ST_EXEC: begin
        if (stat.is_mul) begin
          cmd.mul_capture = 1'b1;
          state_nxt       = rvx_pkg::ST_MUL;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = rvx_pkg::ST_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = rvx_pkg::ST_IDLE;
        end
      end
      rvx_pkg::ST_MUL: begin
        cmd.commit = 1'b1;
        cmd.sel    = rvx_pkg::RES_MUL;
        state_nxt  = rvx_pkg::ST_IDLE;
      end
      rvx_pkg::ST_DIV: begin
        cmd.sel = rvx_pkg::RES_DIV;
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = rvx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rvx_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != rvx_pkg::ST_IDLE);

endmodule
